/* hdl/salc_pkg.sv */
// Shared types and constants for the set-associative LRU cache simulator.
// Used by the top level and by its port checker; depends on nothing else.
package salc_pkg;

	localparam int DEF_MAX_SET_BITS = 6;
	localparam int DEF_MAX_WAYS     = 4;

	localparam int ADDR_W  = 64;
	localparam int STAMP_W = 32;
	localparam int CNT_W   = 32;
	localparam int CFG_W   = 6;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd2;

	localparam logic [2:0] RST_SET_BITS = 3'd4;
	localparam logic [5:0] RST_OFF_BITS = 6'd4;
	localparam logic [2:0] RST_WAYS     = 3'd1;

	// Request kinds.
	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_STORE  = 2'd1;
	localparam logic [1:0] REQ_MODIFY = 2'd2;
	localparam logic [1:0] REQ_FETCH  = 2'd3;

	typedef enum logic [1:0] {
		OUT_HIT   = 2'd0,
		OUT_FILL  = 2'd1,
		OUT_EVICT = 2'd2
	} outcome_t;

	// One cache line as kept in the set memory; its valid bit lives in flops.
	typedef struct packed {
		logic [ADDR_W-1:0]  tag;
		logic [STAMP_W-1:0] stamp;
	} line_t;

endpackage

/* hdl/set_assoc_lru_cache_sim.sv */
// Top level of the set-associative LRU cache simulator: set memory, valid flops,
// access sequencer, counters and output register. Depends on salc_pkg.
//
// A load or store reads the set's row from the synchronous set memory at the
// transaction edge; then, in the evaluate state, it compares tags, picks the
// line, writes the row back and loads the result register. A modify runs that
// read and write-back twice; an instruction fetch leaves the block idle and
// gives no result. The result register lets the next request in while a result
// waits; a waiting result only holds up the next write-back. Valid bits sit in
// flops cleared by reset, so no clearing pass follows reset. Configuration must
// be written only while idle; the block itself does not enforce it.
module set_assoc_lru_cache_sim #(
	parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
	parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [salc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [salc_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [1:0]                    req_type,
	input  logic [salc_pkg::ADDR_W-1:0]   address,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [1:0]                    outcome,
	output logic                          last_of_run,
	output logic [salc_pkg::CNT_W-1:0]    hit_total,
	output logic [salc_pkg::CNT_W-1:0]    miss_total,
	output logic [salc_pkg::CNT_W-1:0]    evict_total
);
	import salc_pkg::*;

	localparam int SETS  = 1 << MAX_SET_BITS;
	localparam int SET_W = (MAX_SET_BITS < 1) ? 1 : MAX_SET_BITS;
	localparam int SB_W  = (MAX_SET_BITS < 1) ? 1 : $clog2(MAX_SET_BITS + 1);
	localparam int WC_W  = $clog2(MAX_WAYS + 1);
	localparam int WAY_W = (MAX_WAYS < 2) ? 1 : $clog2(MAX_WAYS);
	localparam int SH_W  = $clog2(ADDR_W) + 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_EVAL = 3'b100
	} state_t;

	state_t state_q;

	logic [2:0] cfg_sib_q;
	logic [5:0] cfg_off_q;
	logic [2:0] cfg_ways_q;

	logic [SET_W-1:0]  set_q;
	logic [ADDR_W-1:0] tag_q;
	logic              second_q;

	logic [STAMP_W-1:0] use_clock_q;
	logic [CNT_W-1:0]   hit_cnt_q, miss_cnt_q, evict_cnt_q;

	logic                res_valid_q;
	outcome_t            res_outcome_q;
	logic                res_last_q;
	logic [CNT_W-1:0]    res_hit_q, res_miss_q, res_evict_q;

	line_t [MAX_WAYS-1:0] mem [SETS];
	line_t [MAX_WAYS-1:0] rd_row_s1;
	line_t [MAX_WAYS-1:0] wr_row;
	logic  [MAX_WAYS-1:0] valid_q [SETS];
	logic  [MAX_WAYS-1:0] vrow;

	logic [SB_W-1:0]   s_eff;
	logic [WC_W-1:0]   ways_eff;
	logic [SH_W-1:0]   tag_sh;
	logic [ADDR_W-1:0] addr_shifted, set_mask, tag_d;
	logic [SET_W-1:0]  set_d;

	logic               accept, fire, rd_en;
	logic [SET_W-1:0]   rd_addr;
	logic               hit, inv_found;
	logic [WAY_W-1:0]   hit_way, inv_way, lru_way, pick;
	logic [STAMP_W-1:0] min_stamp, stamp_new;
	logic [CNT_W-1:0]   hit_nx, miss_nx, evict_nx;
	outcome_t           outc;

	// Address split from the live configuration.
	always_comb begin
		s_eff = (cfg_sib_q > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS) : SB_W'(cfg_sib_q);
		if (cfg_ways_q == 3'd0)
			ways_eff = WC_W'(1);
		else if (cfg_ways_q > MAX_WAYS)
			ways_eff = WC_W'(MAX_WAYS);
		else
			ways_eff = WC_W'(cfg_ways_q);
		addr_shifted = address >> cfg_off_q;
		set_mask = (ADDR_W'(1) << s_eff) - ADDR_W'(1);
		set_d    = SET_W'(addr_shifted & set_mask);
		tag_sh   = SH_W'(s_eff) + SH_W'(cfg_off_q);
		tag_d    = (tag_sh >= SH_W'(ADDR_W)) ? '0 : (address >> tag_sh);
	end

	assign accept    = req_valid && (state_q == ST_IDLE);
	assign req_stall = (state_q != ST_IDLE);
	assign fire      = (state_q == ST_EVAL) && (!res_valid_q || !res_stall);
	assign rd_en     = (accept && req_type != REQ_FETCH) || (state_q == ST_READ);
	assign rd_addr   = (state_q == ST_READ) ? set_q : set_d;
	assign vrow      = valid_q[set_q];
	assign stamp_new = use_clock_q + STAMP_W'(1);

	// Way search over the registered row from the set memory.
	always_comb begin
		hit       = 1'b0;
		hit_way   = '0;
		inv_found = 1'b0;
		inv_way   = '0;
		lru_way   = '0;
		min_stamp = rd_row_s1[0].stamp;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (w < int'(ways_eff)) begin
				if (!hit && vrow[w] && rd_row_s1[w].tag == tag_q) begin
					hit     = 1'b1;
					hit_way = WAY_W'(w);
				end
				if (!inv_found && !vrow[w]) begin
					inv_found = 1'b1;
					inv_way   = WAY_W'(w);
				end
				// Strict compare keeps the lowest way on a tie.
				if (w > 0 && rd_row_s1[w].stamp < min_stamp) begin
					min_stamp = rd_row_s1[w].stamp;
					lru_way   = WAY_W'(w);
				end
			end
		end
		if (hit) begin
			pick = hit_way;
			outc = OUT_HIT;
		end else if (inv_found) begin
			pick = inv_way;
			outc = OUT_FILL;
		end else begin
			pick = lru_way;
			outc = OUT_EVICT;
		end
		wr_row = rd_row_s1;
		wr_row[pick].stamp = stamp_new;
		wr_row[pick].tag   = tag_q;
		hit_nx   = (hit && hit_cnt_q != '1) ? hit_cnt_q + CNT_W'(1) : hit_cnt_q;
		miss_nx  = (!hit && miss_cnt_q != '1) ? miss_cnt_q + CNT_W'(1) : miss_cnt_q;
		evict_nx = (outc == OUT_EVICT && evict_cnt_q != '1) ?
			evict_cnt_q + CNT_W'(1) : evict_cnt_q;
	end

	// Set memory: one row per set, with a registered read.
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_row_s1 <= mem[rd_addr];
		if (fire)
			mem[set_q] <= wr_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SETS; i++)
				valid_q[i] <= '0;
		end else if (fire) begin
			valid_q[set_q][pick] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_sib_q  <= RST_SET_BITS;
			cfg_off_q  <= RST_OFF_BITS;
			cfg_ways_q <= RST_WAYS;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SET_BITS: cfg_sib_q  <= cfg_data[2:0];
				CFG_OFF_BITS: cfg_off_q  <= cfg_data;
				CFG_WAYS:     cfg_ways_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			second_q    <= 1'b0;
			use_clock_q <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire)
				res_valid_q <= 1'b1;
			else if (res_valid_q && !res_stall)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && req_type != REQ_FETCH) begin
						second_q <= (req_type == REQ_MODIFY);
						state_q  <= ST_EVAL;
					end
				end
				ST_READ: state_q <= ST_EVAL;
				ST_EVAL: begin
					if (fire) begin
						use_clock_q <= stamp_new;
						hit_cnt_q   <= hit_nx;
						miss_cnt_q  <= miss_nx;
						evict_cnt_q <= evict_nx;
						second_q    <= 1'b0;
						state_q     <= second_q ? ST_READ : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			set_q <= set_d;
			tag_q <= tag_d;
		end
		if (fire) begin
			res_outcome_q <= outc;
			res_last_q    <= !second_q;
			res_hit_q     <= hit_nx;
			res_miss_q    <= miss_nx;
			res_evict_q   <= evict_nx;
		end
	end

	assign res_valid   = res_valid_q;
	assign outcome     = res_outcome_q;
	assign last_of_run = res_last_q;
	assign hit_total   = res_hit_q;
	assign miss_total  = res_miss_q;
	assign evict_total = res_evict_q;

endmodule

/* hdl/salc_checker.sv */
// Port-level checks for the cache simulator, bound to its top level.
// Depends on salc_pkg and on set_assoc_lru_cache_sim.
module salc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_stall,
	input logic [1:0]                 req_type,
	input logic                       res_valid,
	input logic                       res_stall,
	input logic [1:0]                 outcome,
	input logic [salc_pkg::CNT_W-1:0] hit_total,
	input logic [salc_pkg::CNT_W-1:0] miss_total,
	input logic [salc_pkg::CNT_W-1:0] evict_total
);
	import salc_pkg::*;

	// A held result stays valid and keeps its outcome and hit total.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(outcome) && $stable(hit_total))
		else $error("result changed while stalled");

	// An instruction fetch leaves the block free for the next request.
	a_fetch_free: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_type == REQ_FETCH |=> !req_stall)
		else $error("fetch occupied the block");

	// A data access holds off the next request once it is taken.
	a_access_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_type != REQ_FETCH |=> req_stall)
		else $error("data access did not hold off the next request");

	// Evictions are a subset of misses, and a reported hit or eviction shows in its count.
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> miss_total >= evict_total
			&& (outcome != OUT_HIT || hit_total != '0)
			&& (outcome != OUT_EVICT || evict_total != '0))
		else $error("running counts disagree with outcome");

endmodule

bind set_assoc_lru_cache_sim salc_checker u_salc_checker (.*);
